// ----- rtl/core/lobm_pkg.sv -----
// Shared types and codes for the limit order book matcher.
package lobm_pkg;

    localparam int IDENT_W = 32;
    localparam int PRICE_W = 16;
    localparam int QTY_W   = 24;
    localparam int STAMP_W = 32;

    localparam logic MODE_PLACE  = 1'b0;
    localparam logic MODE_CANCEL = 1'b1;
    localparam logic SIDE_BUY    = 1'b0;
    localparam logic SIDE_SELL   = 1'b1;
    localparam logic KIND_FILL   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // One classified request handed from front to back.
    typedef struct packed {
        logic               cancel;
        logic               zero_qty;
        logic [IDENT_W-1:0] ident;
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
    } lobm_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_FILL_OUT,
        ST_REST,
        ST_SUM_SCAN,
        ST_SUM_OUT
    } lobm_state_t;

endpackage

// ----- rtl/core/lobm_front.sv -----
// Front end: accepts requests, classifies them, two-entry queue to the engine.
module lobm_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic [31:0]        s_order_ident,
    input  logic               s_side,
    input  logic [15:0]        s_limit_price,
    input  logic [23:0]        s_order_qty,
    output logic               q_valid,
    input  logic               q_ready,
    output lobm_pkg::lobm_req_t q_req
);
    import lobm_pkg::*;

    lobm_req_t   mem_reg [2];
    logic        wptr_reg, rptr_reg;
    logic [1:0]  cnt_reg;
    lobm_req_t   in_req;
    logic        push, pop;

    always_comb begin
        in_req.cancel   = (s_mode == MODE_CANCEL);
        in_req.zero_qty = (s_order_qty == '0);
        in_req.ident    = s_order_ident;
        in_req.side     = s_side;
        in_req.price    = s_limit_price;
        in_req.qty      = s_order_qty;
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_req   = mem_reg[rptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= in_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> !s_ready) else $error("queue overflow");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> cnt_reg != 2'd0) else $error("pop from empty queue");

endmodule

// ----- rtl/core/lobm_back.sv -----
// Matching engine: slot table, best-maker scan, fills, resting and summary.
module lobm_back #(
    parameter int ORDER_SLOTS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  lobm_pkg::lobm_req_t q_req,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_kind,
    output logic [23:0]         m_fill_qty,
    output logic [31:0]         m_taker_ident,
    output logic [31:0]         m_maker_ident,
    output logic [15:0]         m_best_bid,
    output logic                m_bid_present,
    output logic [15:0]         m_best_ask,
    output logic                m_ask_present,
    output logic                m_rested,
    output logic                m_book_full,
    output logic                m_last
);
    import lobm_pkg::*;

    localparam int IW = $clog2(ORDER_SLOTS);
    localparam int CW = $clog2(ORDER_SLOTS + 1);

    // slot table; valid bits in flops, payload as plain registers
    logic [ORDER_SLOTS-1:0] valid_reg, valid_next;
    logic                   side_reg  [ORDER_SLOTS];
    logic [IDENT_W-1:0]     ident_reg [ORDER_SLOTS];
    logic [PRICE_W-1:0]     price_reg [ORDER_SLOTS];
    logic [QTY_W-1:0]       qty_reg   [ORDER_SLOTS];
    logic [STAMP_W-1:0]     stamp_reg [ORDER_SLOTS];
    logic [STAMP_W-1:0]     arrival_reg, arrival_next;

    lobm_state_t state_reg, state_next;
    lobm_req_t   req_reg, req_next;
    logic [QTY_W-1:0] left_reg, left_next;
    logic [CW-1:0]    nfill_reg, nfill_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic             found_reg, found_next;
    logic [IW-1:0]    best_reg, best_next;
    logic             free_found_reg, free_found_next;
    logic [IW-1:0]    free_reg, free_next;
    logic             rested_reg, rested_next, full_reg, full_next;
    logic             hb_reg, hb_next, ha_reg, ha_next;
    logic [PRICE_W-1:0] bid_reg, bid_next, ask_reg, ask_next;

    // output register
    logic             ov_reg, ov_next;
    logic             okind_reg, okind_next;
    logic [QTY_W-1:0] oqty_reg, oqty_next;
    logic [IDENT_W-1:0] otaker_reg, otaker_next, omaker_reg, omaker_next;
    logic             orested_reg, orested_next, ofull_reg, ofull_next;
    logic [PRICE_W-1:0] obid_reg, obid_next, oask_reg, oask_next;
    logic             ohb_reg, ohb_next, oha_reg, oha_next;

    // scan element
    logic             e_ok, e_better, e_last;
    logic [STAMP_W-1:0] age_e, age_b;
    logic             do_write, do_dec, do_rest, do_cancel_clr;
    logic [QTY_W-1:0] dec_qty;

    assign age_e  = arrival_reg - stamp_reg[idx_reg];
    assign age_b  = arrival_reg - stamp_reg[best_reg];
    assign e_last = (idx_reg == IW'(ORDER_SLOTS - 1));

    always_comb begin
        e_ok = valid_reg[idx_reg] && (side_reg[idx_reg] != req_reg.side) &&
               ((req_reg.side == SIDE_BUY) ? (price_reg[idx_reg] <= req_reg.price)
                                           : (price_reg[idx_reg] >= req_reg.price));
        if (price_reg[idx_reg] != price_reg[best_reg]) begin
            e_better = (req_reg.side == SIDE_BUY) ?
                       (price_reg[idx_reg] < price_reg[best_reg]) :
                       (price_reg[idx_reg] > price_reg[best_reg]);
        end else begin
            e_better = age_e > age_b;
        end
    end

    assign q_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        req_next = req_reg;
        left_next = left_reg;
        nfill_next = nfill_reg;
        idx_next = idx_reg;
        found_next = found_reg;
        best_next = best_reg;
        free_found_next = free_found_reg;
        free_next = free_reg;
        rested_next = rested_reg;
        full_next = full_reg;
        hb_next = hb_reg; ha_next = ha_reg;
        bid_next = bid_reg; ask_next = ask_reg;
        valid_next = valid_reg;
        arrival_next = arrival_reg;
        ov_next = ov_reg && !m_ready;
        okind_next = okind_reg;
        oqty_next = oqty_reg;
        otaker_next = otaker_reg;
        omaker_next = omaker_reg;
        orested_next = orested_reg;
        ofull_next = ofull_reg;
        obid_next = obid_reg;
        oask_next = oask_reg;
        ohb_next = ohb_reg;
        oha_next = oha_reg;
        do_write = 1'b0;
        do_dec = 1'b0;
        do_rest = 1'b0;
        do_cancel_clr = 1'b0;
        dec_qty = '0;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    req_next = q_req;
                    left_next = q_req.qty;
                    nfill_next = '0;
                    rested_next = 1'b0;
                    full_next = 1'b0;
                    idx_next = '0;
                    found_next = 1'b0;
                    free_found_next = 1'b0;
                    if (q_req.cancel || q_req.zero_qty) begin
                        state_next = ST_SUM_SCAN;
                        hb_next = 1'b0; ha_next = 1'b0;
                        bid_next = '0; ask_next = '0;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // one slot per cycle; also note lowest free slot
                if (e_ok && (!found_reg || e_better)) begin
                    found_next = 1'b1;
                    best_next = idx_reg;
                end
                if (!valid_reg[idx_reg] && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_next = idx_reg;
                end
                if (e_last) begin
                    idx_next = '0;
                    state_next = ST_DECIDE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DECIDE: begin
                if (found_reg && left_reg != '0 && nfill_reg != CW'(ORDER_SLOTS)) begin
                    if (!ov_reg || m_ready) begin
                        do_write = 1'b1;
                        ov_next = 1'b1;
                        okind_next = KIND_FILL;
                        otaker_next = req_reg.ident;
                        omaker_next = ident_reg[best_reg];
                        orested_next = 1'b0;
                        ofull_next = 1'b0;
                        obid_next = '0;
                        oask_next = '0;
                        ohb_next = 1'b0;
                        oha_next = 1'b0;
                        if (qty_reg[best_reg] > left_reg) begin
                            oqty_next = left_reg;
                            do_dec = 1'b1;
                            dec_qty = qty_reg[best_reg] - left_reg;
                            left_next = '0;
                        end else begin
                            oqty_next = qty_reg[best_reg];
                            left_next = left_reg - qty_reg[best_reg];
                            valid_next[best_reg] = 1'b0;
                        end
                        nfill_next = nfill_reg + 1'b1;
                        state_next = ST_FILL_OUT;
                    end
                end else begin
                    state_next = ST_REST;
                end
            end
            ST_FILL_OUT: begin
                found_next = 1'b0;
                free_found_next = 1'b0;
                idx_next = '0;
                state_next = (left_reg == '0) ? ST_REST : ST_SCAN;
            end
            ST_REST: begin
                if (left_reg != '0) begin
                    if (free_found_reg) begin
                        do_rest = 1'b1;
                        valid_next[free_reg] = 1'b1;
                        arrival_next = arrival_reg + 1'b1;
                        rested_next = 1'b1;
                    end else begin
                        full_next = 1'b1;
                    end
                end
                hb_next = 1'b0; ha_next = 1'b0;
                bid_next = '0; ask_next = '0;
                idx_next = '0;
                state_next = ST_SUM_SCAN;
            end
            ST_SUM_SCAN: begin
                if (req_reg.cancel && valid_reg[idx_reg] &&
                    ident_reg[idx_reg] == req_reg.ident) begin
                    valid_next[idx_reg] = 1'b0;
                end else if (valid_reg[idx_reg]) begin
                    if (side_reg[idx_reg] == SIDE_BUY) begin
                        if (!hb_reg || price_reg[idx_reg] > bid_reg)
                            bid_next = price_reg[idx_reg];
                        hb_next = 1'b1;
                    end else begin
                        if (!ha_reg || price_reg[idx_reg] < ask_reg)
                            ask_next = price_reg[idx_reg];
                        ha_next = 1'b1;
                    end
                end
                if (e_last) begin
                    state_next = ST_SUM_OUT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SUM_OUT: begin
                if (!ov_reg || m_ready) begin
                    ov_next = 1'b1;
                    okind_next = KIND_SUMMARY;
                    oqty_next = '0;
                    otaker_next = '0;
                    omaker_next = '0;
                    orested_next = rested_reg;
                    ofull_next = full_reg;
                    obid_next = bid_reg;
                    oask_next = ask_reg;
                    ohb_next = hb_reg;
                    oha_next = ha_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            arrival_reg <= '0;
            ov_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            arrival_reg <= arrival_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
        left_reg <= left_next;
        nfill_reg <= nfill_next;
        idx_reg <= idx_next;
        found_reg <= found_next;
        best_reg <= best_next;
        free_found_reg <= free_found_next;
        free_reg <= free_next;
        rested_reg <= rested_next;
        full_reg <= full_next;
        hb_reg <= hb_next; ha_reg <= ha_next;
        bid_reg <= bid_next; ask_reg <= ask_next;
        okind_reg <= okind_next;
        oqty_reg <= oqty_next;
        otaker_reg <= otaker_next;
        omaker_reg <= omaker_next;
        orested_reg <= orested_next;
        ofull_reg <= ofull_next;
        obid_reg <= obid_next;
        oask_reg <= oask_next;
        ohb_reg <= ohb_next;
        oha_reg <= oha_next;
        if (do_dec) qty_reg[best_reg] <= dec_qty;
        if (do_rest) begin
            side_reg[free_reg]  <= req_reg.side;
            ident_reg[free_reg] <= req_reg.ident;
            price_reg[free_reg] <= req_reg.price;
            qty_reg[free_reg]   <= left_reg;
            stamp_reg[free_reg] <= arrival_reg;
        end
    end

    assign m_valid       = ov_reg;
    assign m_kind        = okind_reg;
    assign m_fill_qty    = oqty_reg;
    assign m_taker_ident = otaker_reg;
    assign m_maker_ident = omaker_reg;
    assign m_best_bid    = obid_reg;
    assign m_bid_present = ohb_reg;
    assign m_best_ask    = oask_reg;
    assign m_ask_present = oha_reg;
    assign m_rested      = orested_reg;
    assign m_book_full   = ofull_reg;
    assign m_last        = (okind_reg == KIND_SUMMARY);

    a_rest_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_valid && m_rested && m_book_full)) else $error("rested and full");
    a_idle_nobusy: assert property (@(posedge aclk) disable iff (!aresetn)
        q_ready |-> !(do_write || do_rest)) else $error("table write while idle");
    a_fill_guard: assert property (@(posedge aclk) disable iff (!aresetn)
        do_write |-> valid_reg[best_reg]) else $error("fill against empty slot");
    a_rest_free: assert property (@(posedge aclk) disable iff (!aresetn)
        do_rest |-> !valid_reg[free_reg]) else $error("rest into used slot");

endmodule

// ----- rtl/core/limit_order_book_matcher.sv -----
// Top level of the price-time priority limit order book matcher.
//
// Input channel (s_*): one request per place or cancel order, valid/ready.
// Output channel (m_*): zero or more fill results (kind 0), then one summary
// (kind 1, last 1) carrying best bid/ask, presence flags, rested, book_full.
// A two-entry queue sits between the front end and the matching engine, so
// a new request is taken while the engine or the receiver is busy.
// The engine walks the slot table one slot per cycle. A cancel or
// zero-quantity place runs only the summary scan; a place rescans after each
// fill that leaves quantity, then rests any remainder and runs the summary
// scan. The table scan is the limiting loop; one request is processed at a time.
// Results sit in an output register; a stalled receiver holds the engine
// only when a new result is ready to load.
// Reset (aresetn low, synchronous): the book is emptied, the arrival
// counter cleared, the queue and output register emptied. No clearing pass.
module limit_order_book_matcher #(
    parameter int ORDER_SLOTS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [31:0] s_order_ident,
    input  logic        s_side,
    input  logic [15:0] s_limit_price,
    input  logic [23:0] s_order_qty,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [23:0] m_fill_qty,
    output logic [31:0] m_taker_ident,
    output logic [31:0] m_maker_ident,
    output logic [15:0] m_best_bid,
    output logic        m_bid_present,
    output logic [15:0] m_best_ask,
    output logic        m_ask_present,
    output logic        m_rested,
    output logic        m_book_full,
    output logic        m_last
);
    import lobm_pkg::*;

    logic      q_valid, q_ready;
    lobm_req_t q_req;

    // front: accept and classify requests
    lobm_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_mode, .s_order_ident,
        .s_side, .s_limit_price, .s_order_qty,
        .q_valid, .q_ready, .q_req
    );

    // back: matching engine over the slot table
    lobm_back #(.ORDER_SLOTS(ORDER_SLOTS)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_req,
        .m_valid, .m_ready, .m_kind, .m_fill_qty, .m_taker_ident,
        .m_maker_ident, .m_best_bid, .m_bid_present, .m_best_ask,
        .m_ask_present, .m_rested, .m_book_full, .m_last
    );

endmodule
